// ===== design/fp16u_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp16u_pkg
// Types, stage map and per-stage datapath functions of the half-precision
// unary element unit.
// ----------------------------------------------------------------------------
package fp16u_pkg;

    typedef enum logic [3:0] {
        OP_ABS    = 4'd0,
        OP_NEG    = 4'd1,
        OP_FLOOR  = 4'd2,
        OP_CEIL   = 4'd3,
        OP_SQUARE = 4'd4,
        OP_SQRT   = 4'd5,
        OP_RSQRT  = 4'd6,
        OP_RECIP  = 4'd7,
        OP_ROUND  = 4'd8,
        OP_TRUNC  = 4'd9
    } t_op;

    localparam logic [2:0]  ADDR_OP_MODE = 3'd0;
    localparam logic [15:0] CANON_NAN    = 16'h7E00;
    localparam logic [15:0] POS_INF      = 16'h7C00;

    // stage map
    localparam int unsigned ST_DEC = 1;
    localparam int unsigned ST_SQ0 = 2;
    localparam int unsigned ST_SQN = 13;
    localparam int unsigned ST_SQF = 14;
    localparam int unsigned ST_DV0 = 15;
    localparam int unsigned ST_DVN = 29;
    localparam int unsigned ST_PK1 = 30;
    localparam int unsigned ST_PK2 = 31;
    localparam int unsigned NST    = 32;

    typedef struct packed {
        t_op               op;
        logic              sgn;
        logic              spc;
        logic [15:0]       sval;
        logic signed [8:0] e;
        logic [10:0]       nm;
        logic [21:0]       pm;
        logic signed [8:0] pe;
        logic              pst;
        logic signed [8:0] ps;
        logic signed [8:0] pu;
        logic [23:0]       rad;
        logic [13:0]       srem;
        logic [11:0]       root;
        logic [11:0]       drem;
        logic [14:0]       quo;
    } t_stage;

    function automatic logic [3:0] f_lz11(logic [10:0] m);
        logic [3:0] lz;
        lz = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (m[i]) begin
                lz = 4'(10 - i);
            end
        end
        return lz;
    endfunction

    function automatic logic [4:0] f_msb22(logic [21:0] m);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 22; i++) begin
            if (m[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // classify, normalise, square product, integer rounding, special results
    function automatic t_stage f_decode(t_stage a);
        t_stage            r;
        logic [15:0]       v;
        logic [4:0]        ef;
        logic [9:0]        fr;
        logic              nan, inf, zero, sg;
        logic [10:0]       m;
        logic signed [8:0] er;
        logic [3:0]        lz;
        logic [34:0]       ext;
        logic [8:0]        sh;
        logic [16:0]       mag;
        logic [16:0]       sat;
        logic              half, low, up, ineg;
        r    = a;
        v    = a.sval;
        ef   = v[14:10];
        fr   = v[9:0];
        sg   = v[15];
        nan  = (ef == 5'h1F) && (fr != 10'd0);
        inf  = (ef == 5'h1F) && (fr == 10'd0);
        zero = (v[14:0] == 15'd0);
        m    = (ef == 5'd0) ? {1'b0, fr} : {1'b1, fr};
        er   = (ef == 5'd0) ? -9'sd24 : ($signed({4'b0, ef}) - 9'sd25);
        lz   = f_lz11(m);
        r.nm   = m << lz;
        r.e    = er - $signed({5'b0, lz});
        r.rad  = {(r.e[0] ? {r.nm, 1'b0} : {1'b0, r.nm}), 12'd0};
        r.srem = '0;
        r.root = '0;
        r.drem = '0;
        r.quo  = '0;
        r.pst  = 1'b0;
        r.ps   = '0;
        r.pu   = '0;
        r.pm   = {11'd0, m} * {11'd0, m};
        r.pe   = er + er;
        r.sgn  = 1'b0;
        r.spc  = 1'b0;
        // integer rounding path
        sh  = 9'(-er);
        ext = {m, 24'd0} >> sh[4:0];
        if (!er[8]) begin
            mag  = 17'(m) << er[2:0];
            half = 1'b0;
            low  = 1'b0;
        end else begin
            mag  = {6'd0, ext[34:24]};
            half = ext[23];
            low  = |ext[22:0];
        end
        case (a.op)
            OP_ROUND: up = half && (low || mag[0]);
            OP_FLOOR: up = sg && (half || low);
            OP_CEIL:  up = !sg && (half || low);
            default:  up = 1'b0;
        endcase
        mag  = mag + 17'(up);
        ineg = sg;
        if (nan) begin
            sat  = 17'd32767;
            ineg = 1'b0;
        end else if (sg) begin
            sat = (inf || mag > 17'd32768) ? 17'd32768 : mag;
        end else begin
            sat = (inf || mag > 17'd32767) ? 17'd32767 : mag;
        end
        case (a.op) inside
            OP_ABS: begin
                r.spc  = 1'b1;
                r.sval = {1'b0, v[14:0]};
            end
            OP_NEG: begin
                r.spc  = 1'b1;
                r.sval = {~v[15], v[14:0]};
            end
            OP_FLOOR, OP_CEIL, OP_ROUND, OP_TRUNC: begin
                r.pm  = {5'd0, sat};
                r.pe  = '0;
                r.sgn = ineg && (sat != 17'd0);
            end
            OP_SQUARE: begin
                r.spc  = nan || inf;
                r.sval = nan ? CANON_NAN : POS_INF;
            end
            OP_SQRT: begin
                r.spc = nan || zero || sg || inf;
                if (nan || (sg && !zero)) begin
                    r.sval = CANON_NAN;
                end else if (zero) begin
                    r.sval = v;
                end else begin
                    r.sval = POS_INF;
                end
            end
            OP_RSQRT: begin
                r.spc = nan || zero || sg || inf;
                if (nan || (sg && !zero)) begin
                    r.sval = CANON_NAN;
                end else if (zero) begin
                    r.sval = {sg, POS_INF[14:0]};
                end else begin
                    r.sval = 16'd0;
                end
            end
            OP_RECIP: begin
                r.spc = nan || zero || inf;
                r.sgn = sg;
                if (nan) begin
                    r.sval = CANON_NAN;
                end else if (inf) begin
                    r.sval = {sg, 15'd0};
                end else begin
                    r.sval = {sg, POS_INF[14:0]};
                end
            end
            default: begin
                r.spc  = 1'b1;
                r.sval = v;
            end
        endcase
        return r;
    endfunction

    // one restoring square-root digit
    function automatic t_stage f_sqrt_step(t_stage a);
        t_stage      r;
        logic [15:0] t, tr;
        logic        ge;
        r  = a;
        t  = {a.srem, a.rad[23:22]};
        tr = {2'b0, a.root, 2'b01};
        ge = (t >= tr);
        r.srem = ge ? 14'(t - tr) : t[13:0];
        r.root = {a.root[10:0], ge};
        r.rad  = a.rad << 2;
        return r;
    endfunction

    // round the root to 11 bits; seed the divider
    function automatic t_stage f_sqrt_fin(t_stage a);
        t_stage            r;
        logic [10:0]       q, s;
        logic [11:0]       q1;
        logic              up;
        logic signed [8:0] es, ex, bx;
        r  = a;
        q  = a.root[11:1];
        up = a.root[0] && ((a.srem != 14'd0) || q[0]);
        q1 = {1'b0, q} + 12'(up);
        es = ((a.e - $signed({8'd0, a.e[0]})) >>> 1) - 9'sd5;
        if (q1[11]) begin
            s  = 11'h400;
            ex = es + 9'sd1;
        end else begin
            s  = q1[10:0];
            ex = es;
        end
        bx = ex + 9'sd25;
        if (a.op == OP_SQRT && !a.spc) begin
            r.spc  = 1'b1;
            r.sval = {1'b0, bx[4:0], s[9:0]};
        end
        if (a.op == OP_RSQRT) begin
            r.nm = s;
            r.e  = ex;
        end
        r.drem = 12'd512;
        r.quo  = '0;
        return r;
    endfunction

    // one restoring division digit of 2^24 / nm
    function automatic t_stage f_div_step(t_stage a);
        t_stage      r;
        logic [12:0] t;
        logic        ge;
        r  = a;
        t  = {a.drem, 1'b0};
        ge = (t >= {2'b0, a.nm});
        r.drem = ge ? 12'(t - {2'b0, a.nm}) : t[11:0];
        r.quo  = {a.quo[13:0], ge};
        return r;
    endfunction

    // leading-one search and shift amounts for the final rounding
    function automatic t_stage f_pack_prep(t_stage a);
        t_stage            r;
        logic [4:0]        p;
        logic signed [8:0] top, big, s;
        r = a;
        if (a.op == OP_RSQRT || a.op == OP_RECIP) begin
            r.pm  = {7'd0, a.quo};
            r.pe  = -9'sd24 - a.e;
            r.pst = (a.drem != 12'd0);
        end
        p   = f_msb22(r.pm);
        top = $signed({4'd0, p}) + r.pe;
        big = (top < -9'sd14) ? -9'sd14 : top;
        r.pu = big - 9'sd10;
        s    = r.pu - r.pe;
        r.ps = (s > 9'sd23) ? 9'sd23 : s;
        return r;
    endfunction

    // shift, round to nearest even, assemble binary16
    function automatic t_stage f_pack(t_stage a);
        t_stage            r;
        logic [44:0]       ext;
        logic [21:0]       sl;
        logic [8:0]        ns;
        logic [11:0]       qq;
        logic              half, low;
        logic signed [8:0] ex;
        logic [16:0]       val;
        r   = a;
        ns  = 9'(-a.ps);
        sl  = a.pm << ns[3:0];
        ext = {a.pm, 23'd0} >> a.ps[4:0];
        if (a.ps <= 9'sd0) begin
            qq = sl[11:0];
        end else begin
            qq   = ext[34:23];
            half = ext[22];
            low  = (|ext[21:0]) || a.pst;
            qq   = qq + 12'(half && (low || qq[0]));
        end
        ex  = a.pu + 9'sd24;
        val = {ex[6:0], 10'd0} + {5'd0, qq};
        if (val >= {1'b0, POS_INF}) begin
            val = {1'b0, POS_INF};
        end
        if (a.spc) begin
            r.sval = a.sval;
        end else if (a.pm == 22'd0) begin
            r.sval = {a.sgn, 15'd0};
        end else begin
            r.sval = {a.sgn, val[14:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/fp16_unary_elementwise_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp16_unary_elementwise_unit
// Pipelined binary16 unary operator: abs, neg, floor, ceil, square, sqrt,
// rsqrt, reciprocal, round and trunc.
// ----------------------------------------------------------------------------
// Usage:
//   Operands arrive as beats on i_value_bits with i_valid / o_ready; results
//   leave as beats on o_result_bits with o_valid / i_ready. One result beat
//   per operand beat, in order.
//   The operation comes from op_mode (APB offset 0x0); write it only while
//   the pipeline is drained. Each beat takes the op_mode seen at entry.
//   Stages: an entry register, decode, 12 square-root digit stages, root
//   rounding, 15 divide digit stages and two packing stages, the same path
//   for every operation. Throughput: one beat per cycle while i_ready holds;
//   the digit-per-stage sqrt and divide units set the depth, not the rate.
//   Every stage carries its own valid bit and loads whenever it is empty or
//   the stage after it moves, so bubbles collapse and a stalled receiver
//   only holds the beats that are stuck behind the output register. Input
//   stays open while any stage downstream has room.
//   Reset (synchronous, active low) drops all valid bits and sets op_mode
//   to abs.
// ----------------------------------------------------------------------------
module fp16_unary_elementwise_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result_bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fp16u_pkg::*;

    logic [3:0]     r_op_mode, n_op_mode;
    t_stage         r_st [NST];
    t_stage         n_st [NST];
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    // register port: always ready, single register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_OP_MODE) ? {28'd0, r_op_mode} : 32'd0;

    always_comb begin
        n_op_mode = r_op_mode;
        if (psel && penable && pwrite && paddr == ADDR_OP_MODE) begin
            n_op_mode = pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= 4'(OP_ABS);
        end else begin
            r_op_mode <= n_op_mode;
        end
    end

    // a stage may load when empty or when its successor advances
    always_comb begin
        en[NST-1] = ~r_vld[NST-1] | i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign o_ready       = en[0];
    assign o_valid       = r_vld[NST-1];
    assign o_result_bits = r_st[NST-1].sval;

    // entry stage: capture operand and the operation in force
    always_comb begin
        n_st[0]      = '0;
        n_st[0].op   = t_op'(r_op_mode);
        n_st[0].sval = i_value_bits;
    end

    for (genvar k = 1; k < NST; k++) begin : g_stage
        if (k == ST_DEC) begin : g_dec
            always_comb n_st[k] = f_decode(r_st[k-1]);
        end else if (k >= ST_SQ0 && k <= ST_SQN) begin : g_sqrt
            always_comb n_st[k] = f_sqrt_step(r_st[k-1]);
        end else if (k == ST_SQF) begin : g_sqf
            always_comb n_st[k] = f_sqrt_fin(r_st[k-1]);
        end else if (k >= ST_DV0 && k <= ST_DVN) begin : g_div
            always_comb n_st[k] = f_div_step(r_st[k-1]);
        end else if (k == ST_PK1) begin : g_pk1
            always_comb n_st[k] = f_pack_prep(r_st[k-1]);
        end else begin : g_pk2
            always_comb n_st[k] = f_pack(r_st[k-1]);
        end
    end

    // valid bits advance with the data; hold where the next stage is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule

// ===== design/fp16u_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp16u_chk
// Port-level checks of the unary element unit, bound to its top level.
// ----------------------------------------------------------------------------
module fp16u_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [15:0] i_value_bits,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_result_bits,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import fp16u_pkg::*;

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_bits))
        else $error("stalled result beat changed or dropped");

    a_room_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with an empty output stage");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr == ADDR_OP_MODE
        |=> paddr != ADDR_OP_MODE || prdata[3:0] == $past(pwdata[3:0]))
        else $error("op_mode read-back mismatch");

endmodule

bind fp16_unary_elementwise_unit fp16u_chk u_chk (.*);
